[design/fseg_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and control structs of the message frame segmenter.
// Used by fseg_pcell, fseg_wcell and message_frame_segmenter; depends on nothing.
package fseg_pkg;

	localparam int FRAME_WORDS = 8;
	localparam int FRAME_BYTES = FRAME_WORDS * 4;
	localparam int PAYLOAD_MAX = 31;
	localparam int CNT_W = 5;
	localparam int OCNT_W = $clog2(FRAME_WORDS + 1);

	localparam int FIRST_BIT = 7;
	localparam int LAST_BIT = 6;

	typedef logic [7:0] byte_t;
	typedef logic [31:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [OCNT_W-1:0] ocnt_t;

	typedef struct packed {
		logic take;
		logic clear;
	} pcell_ctl_t;

	typedef struct packed {
		logic load;
		logic shift;
	} wcell_ctl_t;

endpackage

[design/fseg_pcell.sv]
`timescale 1ns / 1ps
// One payload cell: holds a byte and a full flag, and takes the offered byte when
// its lower neighbor is full and it is still empty. Depends on fseg_pkg.
module fseg_pcell (
	input  logic               clk,
	input  logic               arst_n,
	input  fseg_pkg::pcell_ctl_t ctl,
	input  fseg_pkg::byte_t    din,
	input  logic               prev_full,
	output logic               full,
	output fseg_pkg::byte_t    dout
);

	logic            full_q;
	fseg_pkg::byte_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (ctl.clear) begin
			full_q <= 1'b0;
		end else if (ctl.take && prev_full && !full_q) begin
			full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take && prev_full && !full_q) begin
			byte_q <= din;
		end
	end

	assign full = full_q;
	assign dout = full_q ? byte_q : 8'h00;

endmodule

[design/fseg_wcell.sv]
`timescale 1ns / 1ps
// One output word cell: loads a frame word in parallel and shifts the word of its
// upper neighbor in on every sent beat. Depends on fseg_pkg.
module fseg_wcell (
	input  logic                 clk,
	input  fseg_pkg::wcell_ctl_t ctl,
	input  fseg_pkg::word_t      load_word,
	input  fseg_pkg::word_t      next_word,
	output fseg_pkg::word_t      word
);

	fseg_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= load_word;
		end else if (ctl.shift) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule

[design/message_frame_segmenter.sv]
`timescale 1ns / 1ps
// Top level of the message frame segmenter.
// Depends on fseg_pkg, fseg_pcell and fseg_wcell.
//
// The slave channel takes one message byte per beat, tlast marking the final byte.
// Bytes fill a row of 31 payload cells. When the 31st byte or a final byte is
// taken, the frame is closed: the slave side stalls while the header and payload
// are copied into a row of eight word cells, then takes bytes again. The master
// channel sends the frame as eight little-endian words, header in bits 7..0 of
// the first word, tlast on the eighth; payload bytes past the count are zero.
// The first word is offered the cycle after the copy. Sustained rate is one byte
// per cycle apart from the stall at each frame close, as long as the eight words
// drain before the next frame closes. If the receiver stalls, the word row holds,
// a closed frame waits in the payload cells and the slave side stalls until the
// word row is free. Reset empties the payload row, leaves the word row with
// nothing to send and marks the next frame as the first of a message.
module message_frame_segmenter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] frame_word
	output logic        m_tlast    // frame_done
);

	logic                 s_acc;
	logic                 m_acc;
	logic                 closing;
	logic                 load;
	logic                 out_free;
	fseg_pkg::cnt_t       fill_cnt_q;
	logic                 first_q;
	logic                 pend_q;
	fseg_pkg::byte_t      hdr_q;
	fseg_pkg::ocnt_t      ocnt_q;
	fseg_pkg::pcell_ctl_t pctl;
	fseg_pkg::wcell_ctl_t wctl;
	logic [5:0]           cnt_next;

	logic [fseg_pkg::PAYLOAD_MAX:0]  full_chain;
	fseg_pkg::byte_t                 pbyte [fseg_pkg::PAYLOAD_MAX];
	fseg_pkg::byte_t                 fbyte [fseg_pkg::FRAME_BYTES];
	fseg_pkg::word_t                 lword [fseg_pkg::FRAME_WORDS];
	fseg_pkg::word_t                 wword [fseg_pkg::FRAME_WORDS+1];

	assign s_tready = !pend_q;
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign closing  = s_acc && (s_tlast || fill_cnt_q == fseg_pkg::cnt_t'(fseg_pkg::PAYLOAD_MAX - 1));
	assign out_free = (ocnt_q == '0) || (ocnt_q == fseg_pkg::ocnt_t'(1) && m_acc);
	assign load     = pend_q && out_free;
	assign cnt_next = {1'b0, fill_cnt_q} + 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
			first_q    <= 1'b1;
			pend_q     <= 1'b0;
			ocnt_q     <= '0;
		end else begin
			if (load) begin
				fill_cnt_q <= '0;
			end else if (s_acc) begin
				fill_cnt_q <= cnt_next[fseg_pkg::CNT_W-1:0];
			end
			if (closing) begin
				first_q <= s_tlast;
				pend_q  <= 1'b1;
			end else if (load) begin
				pend_q  <= 1'b0;
			end
			if (load) begin
				ocnt_q <= fseg_pkg::ocnt_t'(fseg_pkg::FRAME_WORDS);
			end else if (m_acc) begin
				ocnt_q <= ocnt_q - fseg_pkg::ocnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (closing) begin
			hdr_q <= {first_q, s_tlast, cnt_next};
		end
	end

	assign pctl.take  = s_acc;
	assign pctl.clear = load;
	assign full_chain[0] = 1'b1;

	for (genvar i = 0; i < fseg_pkg::PAYLOAD_MAX; i++) begin : g_pcell
		fseg_pcell u_pcell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (pctl),
			.din       (s_tdata),
			.prev_full (full_chain[i]),
			.full      (full_chain[i+1]),
			.dout      (pbyte[i])
		);
	end

	always_comb begin
		fbyte[0] = hdr_q;
		for (int k = 1; k < fseg_pkg::FRAME_BYTES; k++) begin
			if (k <= fseg_pkg::PAYLOAD_MAX) begin
				fbyte[k] = pbyte[k-1];
			end else begin
				fbyte[k] = 8'h00;
			end
		end
		for (int w = 0; w < fseg_pkg::FRAME_WORDS; w++) begin
			lword[w] = {fbyte[4*w+3], fbyte[4*w+2], fbyte[4*w+1], fbyte[4*w]};
		end
	end

	assign wctl.load  = load;
	assign wctl.shift = m_acc;
	assign wword[fseg_pkg::FRAME_WORDS] = '0;

	for (genvar w = 0; w < fseg_pkg::FRAME_WORDS; w++) begin : g_wcell
		fseg_wcell u_wcell (
			.clk       (clk),
			.ctl       (wctl),
			.load_word (lword[w]),
			.next_word (wword[w+1]),
			.word      (wword[w])
		);
	end

	assign m_tvalid = ocnt_q != '0;
	assign m_tlast  = ocnt_q == fseg_pkg::ocnt_t'(1);
	assign m_tdata  = wword[0];

endmodule
